FILE: rtl/core/pf_pkg.sv
package pf_pkg;

    localparam int SQ_SIDE     = 5;
    localparam int LETTER_BITS = 5;

    typedef logic [LETTER_BITS-1:0]         t_letter;
    typedef logic [SQ_SIDE*LETTER_BITS-1:0] t_row;
    typedef t_row [SQ_SIDE-1:0]             t_square;
    typedef logic [2:0]                     t_coord;
    typedef logic [2:0]                     t_cfg_index;

    localparam t_letter LETTER_I = 5'd8;
    localparam t_letter LETTER_J = 5'd9;
    localparam t_letter LETTER_X = 5'd23;

    localparam t_cfg_index CFG_SQUARE_ROW0 = 3'd0;
    localparam t_cfg_index CFG_SQUARE_ROW1 = 3'd1;
    localparam t_cfg_index CFG_SQUARE_ROW2 = 3'd2;
    localparam t_cfg_index CFG_SQUARE_ROW3 = 3'd3;
    localparam t_cfg_index CFG_SQUARE_ROW4 = 3'd4;

    localparam t_row SQUARE_ROW0_RESET = 25'd4294688;
    localparam t_row SQUARE_ROW1_RESET = 25'd10755269;
    localparam t_row SQUARE_ROW2_RESET = 25'd16201099;
    localparam t_row SQUARE_ROW3_RESET = 25'd21613104;
    localparam t_row SQUARE_ROW4_RESET = 25'd27025109;

    // one digraph waiting for the square lookup
    typedef struct packed {
        t_letter first;
        t_letter second;
        logic    last;
    } t_job;

    typedef struct packed {
        t_coord row;
        t_coord col;
    } t_pos;

    function automatic t_letter sq_entry(t_square sq, t_coord row, t_coord col);
        return sq[row][LETTER_BITS*col +: LETTER_BITS];
    endfunction

    // last match wins: highest row with a hit, then highest column in it
    function automatic t_pos sq_locate(t_square sq, t_letter letter);
        logic [SQ_SIDE-1:0] hit_row;
        t_pos               pos;
        hit_row = '0;
        for (int r = 0; r < SQ_SIDE; r++) begin
            for (int c = 0; c < SQ_SIDE; c++) begin
                if (sq[r][LETTER_BITS*c +: LETTER_BITS] == letter) begin
                    hit_row[r] = 1'b1;
                end
            end
        end
        pos.row = '0;
        for (int r = 0; r < SQ_SIDE; r++) begin
            if (hit_row[r]) begin
                pos.row = 3'(r);
            end
        end
        pos.col = '0;
        for (int c = 0; c < SQ_SIDE; c++) begin
            if (sq[pos.row][LETTER_BITS*c +: LETTER_BITS] == letter) begin
                pos.col = 3'(c);
            end
        end
        return pos;
    endfunction

    function automatic t_coord wrap_inc(t_coord v);
        return (v == 3'(SQ_SIDE - 1)) ? 3'd0 : 3'(v + 3'd1);
    endfunction

endpackage

FILE: rtl/core/pf_letter_if.sv
interface pf_letter_if;
    import pf_pkg::*;

    logic    valid;
    logic    ready;
    t_letter plain_letter;
    logic    last_letter;

    modport source (output valid, output plain_letter, output last_letter, input ready);
    modport sink   (input valid, input plain_letter, input last_letter, output ready);
endinterface

FILE: rtl/core/pf_cipher_if.sv
interface pf_cipher_if;
    import pf_pkg::*;

    logic    valid;
    logic    ready;
    t_letter cipher_first;
    t_letter cipher_second;
    logic    last_pair;

    modport source (output valid, output cipher_first, output cipher_second,
                    output last_pair, input ready);
    modport sink   (input valid, input cipher_first, input cipher_second,
                    input last_pair, output ready);
endinterface

FILE: rtl/core/pf_cfg_if.sv
interface pf_cfg_if;
    import pf_pkg::*;

    logic       valid;
    logic       ready;
    t_cfg_index index;
    t_row       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/playfair_digraph_encrypt.sv
// Playfair encryptor. Plaintext letters (a is 0, j folded into i) enter on
// i_letter, one per cycle when not stalled; digraphs leave on o_cipher as letter
// indices with last_pair marking the end of the message. A doubled letter
// inside a pair gets the filler x, an odd final letter is padded with x. The
// 5x5 key square sits in five row registers written through i_cfg (index 0..4,
// column c at bits 5c+4..5c, other indices dropped); they reset to the plain
// a..z square without j, and must be written only while the block is idle.
// Throughput is one letter per cycle while the queue has room; a doubled final
// letter yields two digraphs and holds i_letter.ready low while the second
// waits, since the front pushes one digraph per cycle into the queue. A digraph
// is written into a queue slot, then looked up in the square into the output
// register, from which it leaves on o_cipher.
module playfair_digraph_encrypt #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pf_letter_if.sink   i_letter,
    pf_cfg_if.sink      i_cfg,
    pf_cipher_if.source o_cipher
);
    import pf_pkg::*;

    // key square rows
    t_square r_square;

    // front to queue
    logic push_valid, push_ready;
    t_job push_job;

    // queue to back
    logic pop_valid, pop_ready;
    t_job pop_job;

    // config writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square[0] <= SQUARE_ROW0_RESET;
            r_square[1] <= SQUARE_ROW1_RESET;
            r_square[2] <= SQUARE_ROW2_RESET;
            r_square[3] <= SQUARE_ROW3_RESET;
            r_square[4] <= SQUARE_ROW4_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SQUARE_ROW0: r_square[0] <= i_cfg.data;
                CFG_SQUARE_ROW1: r_square[1] <= i_cfg.data;
                CFG_SQUARE_ROW2: r_square[2] <= i_cfg.data;
                CFG_SQUARE_ROW3: r_square[3] <= i_cfg.data;
                CFG_SQUARE_ROW4: r_square[4] <= i_cfg.data;
                default: ;  // unknown register, write dropped
            endcase
        end
    end

    // pairing: held letter, doubled-letter filler, final padding
    pf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_letter     (i_letter),
        .o_push_valid (push_valid),
        .o_push_job   (push_job),
        .i_push_ready (push_ready)
    );

    // digraph queue between pairing and lookup
    pf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_job   (push_job),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_job    (pop_job),
        .i_pop_ready  (pop_ready)
    );

    // square lookup and row / column / rectangle rule
    pf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_square    (r_square),
        .i_job_valid (pop_valid),
        .i_job       (pop_job),
        .o_job_ready (pop_ready),
        .o_cipher    (o_cipher)
    );

endmodule

FILE: rtl/core/pf_front.sv
module pf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pf_letter_if.sink     i_letter,
    output logic          o_push_valid,
    output pf_pkg::t_job  o_push_job,
    input  logic          i_push_ready
);
    import pf_pkg::*;

    logic    r_held_valid, n_held_valid;
    t_letter r_held_letter, n_held_letter;
    logic    r_pend_valid, n_pend_valid;
    t_job    r_pend_job, n_pend_job;

    logic    accept;
    t_letter letter;
    logic    emit;
    t_job    job;

    assign i_letter.ready = !r_pend_valid && i_push_ready;
    assign accept = i_letter.valid && i_letter.ready;
    assign letter = (i_letter.plain_letter == LETTER_J) ? LETTER_I : i_letter.plain_letter;

    always_comb begin
        n_held_valid  = r_held_valid;
        n_held_letter = r_held_letter;
        n_pend_valid  = r_pend_valid;
        n_pend_job    = r_pend_job;
        emit          = 1'b0;
        job           = '{first: letter, second: LETTER_X, last: 1'b1};
        if (r_pend_valid && i_push_ready) begin
            n_pend_valid = 1'b0;
        end
        if (accept) begin
            if (!r_held_valid) begin
                if (i_letter.last_letter) begin
                    emit = 1'b1;
                end else begin
                    n_held_valid  = 1'b1;
                    n_held_letter = letter;
                end
            end else if (letter != r_held_letter) begin
                emit         = 1'b1;
                job          = '{first: r_held_letter, second: letter,
                                 last: i_letter.last_letter};
                n_held_valid = 1'b0;
            end else begin
                // doubled letter: filler after the first one
                emit = 1'b1;
                job  = '{first: r_held_letter, second: LETTER_X, last: 1'b0};
                if (i_letter.last_letter) begin
                    n_pend_valid = 1'b1;
                    n_pend_job   = '{first: letter, second: LETTER_X, last: 1'b1};
                    n_held_valid = 1'b0;
                end else begin
                    n_held_letter = letter;
                end
            end
        end
    end

    assign o_push_valid = r_pend_valid || emit;
    assign o_push_job   = r_pend_valid ? r_pend_job : job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid  <= 1'b0;
            r_held_letter <= '0;
            r_pend_valid  <= 1'b0;
        end else begin
            r_held_valid  <= n_held_valid;
            r_held_letter <= n_held_letter;
            r_pend_valid  <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_job <= n_pend_job;
    end

endmodule

FILE: rtl/core/pf_queue.sv
module pf_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    input  pf_pkg::t_job  i_push_job,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output pf_pkg::t_job  o_pop_job,
    input  logic          i_pop_ready
);
    import pf_pkg::*;

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    t_job                r_slots [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic                push, pop;

    assign o_push_ready = (r_count != CNT_BITS'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_slots[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : PTR_BITS'(r_wr_ptr + 1'b1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : PTR_BITS'(r_rd_ptr + 1'b1);
        end
        if (push && !pop) begin
            n_count = CNT_BITS'(r_count + 1'b1);
        end else if (pop && !push) begin
            n_count = CNT_BITS'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slots[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

FILE: rtl/core/pf_back.sv
module pf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pf_pkg::t_square i_square,
    input  logic            i_job_valid,
    input  pf_pkg::t_job    i_job,
    output logic            o_job_ready,
    pf_cipher_if.source     o_cipher
);
    import pf_pkg::*;

    logic    r_out_valid;
    t_letter r_first, r_second;
    logic    r_last;
    t_letter n_first, n_second;

    t_pos pos_a, pos_b;
    t_pos enc_a, enc_b;
    logic take;

    assign o_job_ready = !r_out_valid || o_cipher.ready;
    assign take        = i_job_valid && o_job_ready;

    always_comb begin
        pos_a = sq_locate(i_square, i_job.first);
        pos_b = sq_locate(i_square, i_job.second);
        enc_a = pos_a;
        enc_b = pos_b;
        if (pos_a.row == pos_b.row) begin
            enc_a.col = wrap_inc(pos_a.col);
            enc_b.col = wrap_inc(pos_b.col);
        end else if (pos_a.col == pos_b.col) begin
            enc_a.row = wrap_inc(pos_a.row);
            enc_b.row = wrap_inc(pos_b.row);
        end else begin
            enc_a.col = pos_b.col;
            enc_b.col = pos_a.col;
        end
        n_first  = sq_entry(i_square, enc_a.row, enc_a.col);
        n_second = sq_entry(i_square, enc_b.row, enc_b.col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_job_ready) begin
            r_out_valid <= i_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_first  <= n_first;
            r_second <= n_second;
            r_last   <= i_job.last;
        end
    end

    assign o_cipher.valid         = r_out_valid;
    assign o_cipher.cipher_first  = r_first;
    assign o_cipher.cipher_second = r_second;
    assign o_cipher.last_pair     = r_last;

endmodule

FILE: sim/playfair_digraph_encrypt_tb.sv
`timescale 1ns / 100ps

module playfair_digraph_encrypt_tb;
    import pf_pkg::*;

    localparam int MAX_GAP       = 14;
    localparam int RX_HOLD_LEN   = 300;  // long receiver hold-off, in cycles
    localparam int SETTLE_CYCLES = 8;    // extra wait after the last expected digraph, as margin
    localparam int RUN_LIMIT_NS  = 4_000_000;

    // ------------------------------------------------------------------
    // digraph predictor and store of expected cipher pairs
    // ------------------------------------------------------------------
    class digraph_board;
        t_row    key_rows [SQ_SIDE];
        t_letter held;
        bit      held_ok;
        t_job    want_q [$];
        int      n_letters;
        int      n_pairs;
        int      n_errors;

        function new();
            key_rows[0] = SQUARE_ROW0_RESET;
            key_rows[1] = SQUARE_ROW1_RESET;
            key_rows[2] = SQUARE_ROW2_RESET;
            key_rows[3] = SQUARE_ROW3_RESET;
            key_rows[4] = SQUARE_ROW4_RESET;
            held      = '0;
            held_ok   = 1'b0;
            n_letters = 0;
            n_pairs   = 0;
            n_errors  = 0;
        endfunction

        function void write_row(t_cfg_index idx, t_row value);
            if (idx <= CFG_SQUARE_ROW4) begin
                key_rows[idx] = value;
            end
        endfunction

        function t_letter entry_at(int r, int c);
            return key_rows[r][LETTER_BITS*c +: LETTER_BITS];
        endfunction

        // scan order rows then columns, the later hit overrides
        function void find(t_letter l, output int r, output int c);
            r = 0;
            c = 0;
            for (int rr = 0; rr < SQ_SIDE; rr++) begin
                for (int cc = 0; cc < SQ_SIDE; cc++) begin
                    if (entry_at(rr, cc) == l) begin
                        r = rr;
                        c = cc;
                    end
                end
            end
        endfunction

        function void push_digraph(t_letter a, t_letter b, logic last);
            int   r0, c0, r1, c1, t;
            t_job job;
            find(a, r0, c0);
            find(b, r1, c1);
            if (r0 == r1) begin
                c0 = (c0 + 1) % SQ_SIDE;
                c1 = (c1 + 1) % SQ_SIDE;
            end else if (c0 == c1) begin
                r0 = (r0 + 1) % SQ_SIDE;
                r1 = (r1 + 1) % SQ_SIDE;
            end else begin
                t  = c0;
                c0 = c1;
                c1 = t;
            end
            job.first  = entry_at(r0, c0);
            job.second = entry_at(r1, c1);
            job.last   = last;
            want_q.push_back(job);
        endfunction

        function void take_letter(t_letter raw, logic last);
            t_letter l;
            l = (raw == LETTER_J) ? LETTER_I : raw;
            n_letters++;
            if (!held_ok) begin
                if (last) begin
                    push_digraph(l, LETTER_X, 1'b1);
                end else begin
                    held    = l;
                    held_ok = 1'b1;
                end
            end else if (l != held) begin
                push_digraph(held, l, last);
                held_ok = 1'b0;
            end else begin
                push_digraph(held, LETTER_X, 1'b0);
                if (last) begin
                    push_digraph(l, LETTER_X, 1'b1);
                    held_ok = 1'b0;
                end else begin
                    held = l;
                end
            end
        endfunction

        function void check_digraph(t_letter first, t_letter second, logic last);
            t_job want;
            n_pairs++;
            if (want_q.size() == 0) begin
                $error("unexpected digraph first=%0d second=%0d last=%0b",
                       first, second, last);
                n_errors++;
            end else begin
                want = want_q.pop_front();
                if (first !== want.first) begin
                    $error("cipher_first: expected %0d, got %0d", want.first, first);
                    n_errors++;
                end
                if (second !== want.second) begin
                    $error("cipher_second: expected %0d, got %0d", want.second, second);
                    n_errors++;
                end
                if (last !== want.last) begin
                    $error("last_pair: expected %0b, got %0b", want.last, last);
                    n_errors++;
                end
            end
        endfunction

        function int outstanding();
            return want_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset, channels, block
    // ------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pf_letter_if letter_ch ();
    pf_cfg_if    cfg_ch ();
    pf_cipher_if cipher_ch ();

    playfair_digraph_encrypt i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_letter (letter_ch),
        .i_cfg    (cfg_ch),
        .o_cipher (cipher_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    digraph_board board;

    // sender side pacing
    bit tx_fast     = 1'b0;  // no gaps between letters while set
    bit tx_lock     = 1'b0;  // freezes the pacing mode during pressure tests
    bit rx_hold_req = 1'b0;  // asks the receiver for a long hold-off
    int n_squares   = 0;

    // receiver side pacing
    int rx_wait = 0;
    int rx_hold = 0;
    bit rx_fast = 1'b0;

    // ------------------------------------------------------------------
    // receiver: ready driven at the falling edge, items taken at the rising
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        cipher_ch.ready <= i_rst_n && (rx_wait == 0) && (rx_hold == 0);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_wait = 0;
            rx_hold = 0;
        end else begin
            if (cipher_ch.valid === 1'b1 && cipher_ch.ready === 1'b1) begin
                board.check_digraph(cipher_ch.cipher_first, cipher_ch.cipher_second,
                                    cipher_ch.last_pair);
                // occasionally switch between stalling and full-rate stretches
                if ($urandom_range(0, 49) == 0) begin
                    rx_fast = !rx_fast;
                end
                rx_wait = rx_fast ? 0 : $urandom_range(0, MAX_GAP);
            end else if (rx_wait > 0 && rx_hold == 0) begin
                rx_wait--;
            end
            if (rx_hold > 0) begin
                rx_hold--;
            end
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_hold     = RX_HOLD_LEN;
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one plaintext item; entered and left at a falling edge, valid left high
    task automatic send_letter(input t_letter l, input logic last);
        int gap;
        if (!tx_lock && $urandom_range(0, 49) == 0) begin
            tx_fast = !tx_fast;
        end
        gap = tx_fast ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            letter_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        letter_ch.valid        <= 1'b1;
        letter_ch.plain_letter <= l;
        letter_ch.last_letter  <= last;
        @(posedge i_clk);
        while (letter_ch.ready !== 1'b1) @(posedge i_clk);
        board.take_letter(l, last);
        @(negedge i_clk);
    endtask

    // stop offering letters and wait until every digraph has come out
    task automatic settle();
        letter_ch.valid <= 1'b0;
        while (board.outstanding() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input t_row value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) @(posedge i_clk);
        board.write_row(idx, value);
        @(negedge i_clk);
    endtask

    task automatic load_square(input t_square sq);
        write_reg(CFG_SQUARE_ROW0, sq[0]);
        write_reg(CFG_SQUARE_ROW1, sq[1]);
        write_reg(CFG_SQUARE_ROW2, sq[2]);
        write_reg(CFG_SQUARE_ROW3, sq[3]);
        write_reg(CFG_SQUARE_ROW4, sq[4]);
        cfg_ch.valid <= 1'b0;
        n_squares++;
    endtask

    // 25 distinct letters without j, shuffled
    function automatic t_square shuffled_square();
        t_letter pool [25];
        t_letter t;
        t_square sq;
        int      k, j;
        k = 0;
        for (int l = 0; l < 26; l++) begin
            if (t_letter'(l) != LETTER_J) begin
                pool[k] = t_letter'(l);
                k++;
            end
        end
        for (int i = 24; i > 0; i--) begin
            j       = $urandom_range(0, i);
            t       = pool[i];
            pool[i] = pool[j];
            pool[j] = t;
        end
        for (int r = 0; r < SQ_SIDE; r++) begin
            for (int c = 0; c < SQ_SIDE; c++) begin
                sq[r][LETTER_BITS*c +: LETTER_BITS] = pool[r*SQ_SIDE + c];
            end
        end
        return sq;
    endfunction

    function automatic t_square filled_square(input t_row value);
        t_square sq;
        for (int r = 0; r < SQ_SIDE; r++) begin
            sq[r] = value;
        end
        return sq;
    endfunction

    // random messages ending in a last letter; doubles, x, j and letters
    // off the square are favored, and a few messages carry a stray last mark
    task automatic send_messages(input int n_items);
        int      sent;
        int      len;
        int      pick;
        bit      broken;
        t_letter prev;
        t_letter l;
        logic    last;
        sent = 0;
        prev = '0;
        while (sent < n_items) begin
            len    = $urandom_range(1, 12);
            broken = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < len; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 15 && i > 0) begin
                    l = prev;
                end else if (pick < 23) begin
                    l = LETTER_X;
                end else if (pick < 29) begin
                    l = LETTER_J;
                end else if (pick < 31) begin
                    l = t_letter'($urandom_range(26, 31));
                end else begin
                    l = t_letter'($urandom_range(0, 25));
                end
                last = (i == len - 1) || (broken && $urandom_range(0, 3) == 0);
                send_letter(l, last);
                prev = l;
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        t_square sq;
        bit      failed;
        board = new();
        letter_ch.valid        = 1'b0;
        letter_ch.plain_letter = '0;
        letter_ch.last_letter  = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = CFG_SQUARE_ROW0;
        cfg_ch.data            = '0;
        cipher_ch.ready        = 1'b0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed items against the reset square a..e / f..k / l..p / q..u / v..z
        send_letter(5'd0, 1'b0);         // a b: same row
        send_letter(5'd1, 1'b0);
        send_letter(5'd4, 1'b0);         // e z: same column, z wraps to the top
        send_letter(5'd25, 1'b0);
        send_letter(LETTER_J, 1'b0);     // j folds into i, i k same row with wrap
        send_letter(5'd10, 1'b0);
        send_letter(5'd11, 1'b0);        // l l: filler, second l starts a new pair
        send_letter(5'd11, 1'b0);
        send_letter(5'd6, 1'b0);         // l g: rectangle
        send_letter(LETTER_X, 1'b0);     // doubled x takes x as filler
        send_letter(LETTER_X, 1'b0);
        send_letter(LETTER_X, 1'b1);     // doubled final letter, two digraphs
        send_letter(5'd12, 1'b1);        // lone final letter padded with x
        send_letter(LETTER_I, 1'b0);     // i j: equal after folding, a doubled final letter
        send_letter(LETTER_J, 1'b1);
        send_letter(5'd31, 1'b0);        // letters off the square sit at row 0, col 0
        send_letter(5'd26, 1'b1);
        send_letter(5'd0, 1'b0);
        send_letter(5'd25, 1'b1);
        send_letter(5'd30, 1'b1);
        settle();

        // writes to indexes past the last row, then a well-formed random square
        for (int k = SQ_SIDE; k < 2**$bits(t_cfg_index); k++) begin
            write_reg(t_cfg_index'(k), t_row'($urandom()));
        end
        load_square(shuffled_square());
        send_messages(250);

        // receiver stalls for a long stretch while letters keep coming at full rate
        tx_lock     = 1'b1;
        tx_fast     = 1'b1;
        rx_hold_req = 1'b1;
        send_messages(40);
        tx_lock = 1'b0;
        // sender waits for the block to drain completely
        letter_ch.valid <= 1'b0;
        while (board.outstanding() != 0) @(negedge i_clk);
        send_messages(250);
        settle();

        // all-zero rows: every entry matches letter a, nothing else is found
        load_square(filled_square('0));
        send_messages(60);
        settle();

        // all-ones rows: entries above the alphabet
        load_square(filled_square('1));
        send_messages(60);
        settle();

        // ill-formed square with duplicates and stray codes
        for (int r = 0; r < SQ_SIDE; r++) begin
            for (int c = 0; c < SQ_SIDE; c++) begin
                sq[r][LETTER_BITS*c +: LETTER_BITS] = ($urandom_range(0, 3) == 0) ?
                    t_letter'($urandom_range(0, 31)) : t_letter'($urandom_range(0, 7));
            end
        end
        load_square(sq);
        send_messages(120);
        settle();

        load_square(shuffled_square());
        send_messages(500);
        settle();

        // back to the plain square, written explicitly
        sq[0] = SQUARE_ROW0_RESET;
        sq[1] = SQUARE_ROW1_RESET;
        sq[2] = SQUARE_ROW2_RESET;
        sq[3] = SQUARE_ROW3_RESET;
        sq[4] = SQUARE_ROW4_RESET;
        load_square(sq);
        send_messages(200);
        settle();

        $display("run covered %0d plaintext letters and %0d digraphs under %0d key squares",
                 board.n_letters, board.n_pairs, n_squares);
        $display("squares included the plain one, shuffled, all-zero, all-ones and ill-formed");
        failed = (board.n_errors != 0) || (board.outstanding() != 0);
        if (!failed) begin
            $display("playfair_digraph_encrypt verification clean");
        end else begin
            $display("playfair_digraph_encrypt verification failed");
        end
        $finish;
    end

    // watchdog against a hung handshake
    initial begin
        #(RUN_LIMIT_NS);
        $display("playfair_digraph_encrypt verification failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/pf_pkg.sv
rtl/core/pf_letter_if.sv
rtl/core/pf_cipher_if.sv
rtl/core/pf_cfg_if.sv
rtl/core/pf_front.sv
rtl/core/pf_queue.sv
rtl/core/pf_back.sv
rtl/core/playfair_digraph_encrypt.sv
sim/playfair_digraph_encrypt_tb.sv
